/* src/btpc_pkg.sv */
// ----------------------------------------------------------------------------
// btpc_pkg
// Shared types and constants of the pressure and temperature compensation core.
// ----------------------------------------------------------------------------
package btpc_pkg;

  localparam int SAMPLE_W   = 24;
  localparam int TEMP_W     = 24;
  localparam int PRESS_W    = 26;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  localparam int TEMP_STAGES  = 4;
  localparam int PRESS_STAGES = 7;
  localparam int NSTAGE       = TEMP_STAGES + PRESS_STAGES;

  localparam logic [CFG_IDX_W-1:0] CFG_TEMP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_A = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_B = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_C = 3'd3;

  localparam logic signed [TEMP_W-1:0] TEMP_MAX = 24'sh7fffff;
  localparam logic signed [TEMP_W-1:0] TEMP_MIN = 24'sh800000;
  localparam logic [PRESS_W-1:0]       PRESS_MAX = 26'h3ffffff;

  typedef struct packed {
    logic [15:0]        t1;
    logic [15:0]        t2;
    logic signed [7:0]  t3;
    logic signed [15:0] p1;
    logic signed [15:0] p2;
    logic signed [7:0]  p3;
    logic signed [7:0]  p4;
    logic [15:0]        p5;
    logic [15:0]        p6;
    logic signed [7:0]  p7;
    logic signed [7:0]  p8;
    logic signed [15:0] p9;
    logic signed [7:0]  p10;
    logic signed [7:0]  p11;
  } calib_t;

endpackage

/* src/btpc_ctrl.sv */
// ----------------------------------------------------------------------------
// btpc_ctrl
// Valid bits and per-stage load enables of the pipeline, with bubble removal.
// ----------------------------------------------------------------------------
module btpc_ctrl
  import btpc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              out_stall,
  output logic              in_stall,
  output logic              out_valid,
  output logic [NSTAGE-1:0] en
);

  logic [NSTAGE-1:0] valid;

  always_comb begin
    en[NSTAGE-1] = !valid[NSTAGE-1] || !out_stall;
    for (int i = NSTAGE - 2; i >= 0; i--) begin
      en[i] = !valid[i] || en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (en[0]) begin
        valid[0] <= in_valid;
      end
      for (int i = 1; i < NSTAGE; i++) begin
        if (en[i]) begin
          valid[i] <= valid[i-1];
        end
      end
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = valid[NSTAGE-1];

endmodule

/* src/btpc_temp.sv */
// ----------------------------------------------------------------------------
// btpc_temp
// Temperature stages: linearized temperature, output rounding and clamping.
// ----------------------------------------------------------------------------
module btpc_temp
  import btpc_pkg::*;
#(
  parameter int SAMPLE_BITS    = 24,
  parameter int TEMP_FRAC_BITS = 16
) (
  input  logic                   clk,
  input  logic [TEMP_STAGES-1:0] en,
  input  calib_t                 calib,
  input  logic [SAMPLE_W-1:0]    raw_pressure,
  input  logic [SAMPLE_W-1:0]    raw_temperature,
  output logic signed [TEMP_W-1:0] temp,
  output logic signed [TEMP_W-1:0] tq,
  output logic                   hit,
  output logic [SAMPLE_W-1:0]    rp
);

  localparam int TS = 48 - TEMP_FRAC_BITS;
  localparam logic [SAMPLE_W-1:0] SMASK = SAMPLE_W'((64'd1 << SAMPLE_BITS) - 64'd1);
  localparam logic signed [61:0] TRND  = 62'sd1 <<< (TS - 1);
  localparam logic signed [61:0] QRND  = 62'sd1 <<< 31;
  localparam logic signed [61:0] LO62  = 62'(TEMP_MIN);
  localparam logic signed [61:0] HI62  = 62'(TEMP_MAX);

  logic signed [24:0] d1;
  logic [SAMPLE_W-1:0] rp1, rp2, rp3;
  logic signed [41:0] dt2;
  logic signed [49:0] dd2;
  logic signed [61:0] a3;
  logic signed [57:0] ddt3;
  logic signed [61:0] a_next, tr, tqr;
  logic signed [TEMP_W-1:0] temp_next, tq_next;
  logic hit_next;

  always_comb begin
    ddt3   = 58'(dd2) * 58'(calib.t3);
    a_next = (62'(dt2) <<< 18) + 62'(ddt3);
    tr     = (a3 + TRND) >>> TS;
    tqr    = (a3 + QRND) >>> 32;
    hit_next = 1'b0;
    if (tr < LO62) begin
      temp_next = TEMP_MIN;
      hit_next  = 1'b1;
    end else if (tr > HI62) begin
      temp_next = TEMP_MAX;
      hit_next  = 1'b1;
    end else begin
      temp_next = tr[TEMP_W-1:0];
    end
    if (tqr < LO62) begin
      tq_next  = TEMP_MIN;
      hit_next = 1'b1;
    end else if (tqr > HI62) begin
      tq_next  = TEMP_MAX;
      hit_next = 1'b1;
    end else begin
      tq_next = tqr[TEMP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      rp1 <= raw_pressure & SMASK;
      d1  <= $signed({1'b0, raw_temperature & SMASK}) - $signed({1'b0, calib.t1, 8'h00});
    end
    if (en[1]) begin
      rp2 <= rp1;
      dt2 <= 42'(d1) * 42'($signed({1'b0, calib.t2}));
      dd2 <= 50'(d1) * 50'(d1);
    end
    if (en[2]) begin
      rp3 <= rp2;
      a3  <= a_next;
    end
    if (en[3]) begin
      rp   <= rp3;
      temp <= temp_next;
      tq   <= tq_next;
      hit  <= hit_next;
    end
  end

endmodule

/* src/btpc_press.sv */
// ----------------------------------------------------------------------------
// btpc_press
// Pressure stages: temperature powers, sensitivity, offset, final sum, clamp.
// ----------------------------------------------------------------------------
module btpc_press
  import btpc_pkg::*;
#(
  parameter int PRESS_FRAC_BITS = 8
) (
  input  logic                    clk,
  input  logic [PRESS_STAGES-1:0] en,
  input  calib_t                  calib,
  input  logic signed [TEMP_W-1:0] temp_in,
  input  logic signed [TEMP_W-1:0] tq,
  input  logic                    hit_in,
  input  logic [SAMPLE_W-1:0]     rp,
  output logic signed [TEMP_W-1:0] temperature,
  output logic [PRESS_W-1:0]      pressure,
  output logic                    clipped
);

  localparam int OS = 16 - PRESS_FRAC_BITS;
  localparam int SS = 40 - PRESS_FRAC_BITS;
  localparam int QS = 46 - PRESS_FRAC_BITS;
  localparam int CS = 47 - PRESS_FRAC_BITS;
  localparam logic signed [63:0] PMAX64 = 64'($signed({1'b0, PRESS_MAX}));

  logic signed [TEMP_W-1:0] t5, t6, t7, t8, t9, t10;
  logic h5, h6, h7, h8, h9, h10;
  logic [SAMPLE_W-1:0] rp5, rp6, rp7, rp8;
  logic signed [TEMP_W-1:0] tq5;
  logic signed [47:0] tsqf5;
  logic signed [40:0] p2t5, p6t5, p2t6, p6t6, p2t7, p6t7;
  logic signed [31:0] p10t5, p10t6, p10t7;
  logic signed [55:0] tcuf6;
  logic signed [39:0] p3t6, p7t6, p3t7, p7t7;
  logic signed [47:0] p4t7, p8t7;
  logic signed [47:0] sens8, offs8;
  logic signed [39:0] q8;
  logic [29:0] r2_8;
  logic [43:0] ml9;
  logic signed [52:0] mh9;
  logic [45:0] nl9;
  logic signed [54:0] nh9;
  logic [53:0] r2rp9;
  logic signed [63:0] ot9, ot10, st10, qt10, ct10;

  logic signed [16:0] p1m, p2m;
  logic signed [31:0] tsq_c;
  logic signed [39:0] tcu_c;
  logic [47:0] rpsq;
  logic signed [63:0] ps, pq, pc, pr;

  always_comb begin
    p1m   = 17'(calib.p1) - 17'sd16384;
    p2m   = 17'(calib.p2) - 17'sd16384;
    tsq_c = 32'(tsqf5 >>> 16);
    tcu_c = 40'(tcuf6 >>> 16);
    rpsq  = 48'(rp7) * 48'(rp7);
    ps = (64'(mh9) <<< 20) + 64'($signed({1'b0, ml9}));
    pq = (64'(nh9) <<< 16) + 64'($signed({1'b0, nl9}));
    pc = 64'($signed({1'b0, r2rp9})) * 64'(calib.p11);
    pr = st10 + qt10 + ct10 + ot10;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      t5 <= temp_in; h5 <= hit_in; rp5 <= rp; tq5 <= tq;
      tsqf5 <= 48'(tq) * 48'(tq);
      p2t5  <= 41'(p2m) * 41'(tq);
      p6t5  <= 41'($signed({1'b0, calib.p6})) * 41'(tq);
      p10t5 <= 32'(calib.p10) * 32'(tq);
    end
    if (en[1]) begin
      t6 <= t5; h6 <= h5; rp6 <= rp5;
      p2t6 <= p2t5; p6t6 <= p6t5; p10t6 <= p10t5;
      tcuf6 <= 56'(tsq_c) * 56'(tq5);
      p3t6  <= 40'(calib.p3) * 40'(tsq_c);
      p7t6  <= 40'(calib.p7) * 40'(tsq_c);
    end
    if (en[2]) begin
      t7 <= t6; h7 <= h6; rp7 <= rp6;
      p2t7 <= p2t6; p6t7 <= p6t6; p10t7 <= p10t6;
      p3t7 <= p3t6; p7t7 <= p7t6;
      p4t7 <= 48'(calib.p4) * 48'(tcu_c);
      p8t7 <= 48'(calib.p8) * 48'(tcu_c);
    end
    if (en[3]) begin
      t8 <= t7; h8 <= h7; rp8 <= rp7;
      sens8 <= (48'(p1m) <<< 20) + 48'(p2t7 >>> 5) + 48'(p3t7 >>> 8)
             + 48'(p4t7 >>> 13);
      offs8 <= (48'($signed({1'b0, calib.p5})) <<< 19) + 48'(p6t7 >>> 6)
             + 48'(p7t7 >>> 8) + 48'(p8t7 >>> 15);
      q8    <= (40'(calib.p9) <<< 16) + 40'(p10t7);
      r2_8  <= rpsq[47:18];
    end
    if (en[4]) begin
      t9 <= t8; h9 <= h8;
      ml9   <= 44'(rp8) * 44'(sens8[19:0]);
      mh9   <= 53'($signed({1'b0, rp8})) * 53'($signed(sens8[47:20]));
      nl9   <= 46'(r2_8) * 46'(q8[15:0]);
      nh9   <= 55'($signed({1'b0, r2_8})) * 55'($signed(q8[39:16]));
      r2rp9 <= 54'(r2_8) * 54'(rp8);
      ot9   <= 64'(offs8 >>> OS);
    end
    if (en[5]) begin
      t10 <= t9; h10 <= h9; ot10 <= ot9;
      st10 <= ps >>> SS;
      qt10 <= pq >>> QS;
      ct10 <= pc >>> CS;
    end
    if (en[6]) begin
      temperature <= t10;
      if (pr < 64'sd0) begin
        pressure <= '0;
        clipped  <= 1'b1;
      end else if (pr > PMAX64) begin
        pressure <= PRESS_MAX;
        clipped  <= 1'b1;
      end else begin
        pressure <= pr[PRESS_W-1:0];
        clipped  <= h10;
      end
    end
  end

endmodule

/* src/baro_temp_pressure_compensation_core.sv */
// ----------------------------------------------------------------------------
// baro_temp_pressure_compensation_core
// Barometric temperature and pressure compensation, pipelined.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall) takes one raw pressure and raw temperature
// pair per item. Output channel (out_valid/out_stall) returns temperature
// (degC, signed fixed point), pressure (Pa, unsigned fixed point, saturated)
// and clipped, set when any result or the internal temperature saturated.
// Calibration is written through cfg_valid/cfg_ready/cfg_index/cfg_data:
// index 0 temperature word, 1..3 pressure words; other indexes are ignored.
// cfg_ready is always high; write only while no item is in flight.
// The datapath is 11 register stages, and one item is accepted every cycle
// while in_stall is low. The depth is set by the chain of temperature powers
// and the split wide products.
// Reset clears all valid bits and calibration words. When the receiver
// stalls, items close up behind the output register; in_stall rises only
// once every stage holds an item.
// ----------------------------------------------------------------------------
module baro_temp_pressure_compensation_core
  import btpc_pkg::*;
#(
  parameter int SAMPLE_BITS     = 24,
  parameter int TEMP_FRAC_BITS  = 16,
  parameter int PRESS_FRAC_BITS = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [SAMPLE_W-1:0]    raw_pressure,
  input  logic [SAMPLE_W-1:0]    raw_temperature,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [TEMP_W-1:0] temperature,
  output logic [PRESS_W-1:0]     pressure,
  output logic                   clipped,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [39:0] temp_calib_word;
  logic [47:0] press_calib_word_a, press_calib_word_b;
  logic [31:0] press_calib_word_c;
  calib_t      calib;
  logic [NSTAGE-1:0] en;
  logic signed [TEMP_W-1:0] temp_s, tq_s;
  logic hit_s;
  logic [SAMPLE_W-1:0] rp_s;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_calib_word    <= '0;
      press_calib_word_a <= '0;
      press_calib_word_b <= '0;
      press_calib_word_c <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TEMP:    temp_calib_word    <= cfg_data[39:0];
        CFG_PRESS_A: press_calib_word_a <= cfg_data;
        CFG_PRESS_B: press_calib_word_b <= cfg_data;
        CFG_PRESS_C: press_calib_word_c <= cfg_data[31:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    calib.t1  = temp_calib_word[15:0];
    calib.t2  = temp_calib_word[31:16];
    calib.t3  = $signed(temp_calib_word[39:32]);
    calib.p1  = $signed(press_calib_word_a[15:0]);
    calib.p2  = $signed(press_calib_word_a[31:16]);
    calib.p3  = $signed(press_calib_word_a[39:32]);
    calib.p4  = $signed(press_calib_word_a[47:40]);
    calib.p5  = press_calib_word_b[15:0];
    calib.p6  = press_calib_word_b[31:16];
    calib.p7  = $signed(press_calib_word_b[39:32]);
    calib.p8  = $signed(press_calib_word_b[47:40]);
    calib.p9  = $signed(press_calib_word_c[15:0]);
    calib.p10 = $signed(press_calib_word_c[23:16]);
    calib.p11 = $signed(press_calib_word_c[31:24]);
  end

  btpc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .en        (en)
  );

  btpc_temp #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .TEMP_FRAC_BITS (TEMP_FRAC_BITS)
  ) u_temp (
    .clk             (clk),
    .en              (en[TEMP_STAGES-1:0]),
    .calib           (calib),
    .raw_pressure    (raw_pressure),
    .raw_temperature (raw_temperature),
    .temp            (temp_s),
    .tq              (tq_s),
    .hit             (hit_s),
    .rp              (rp_s)
  );

  btpc_press #(
    .PRESS_FRAC_BITS (PRESS_FRAC_BITS)
  ) u_press (
    .clk         (clk),
    .en          (en[NSTAGE-1:TEMP_STAGES]),
    .calib       (calib),
    .temp_in     (temp_s),
    .tq          (tq_s),
    .hit_in      (hit_s),
    .rp          (rp_s),
    .temperature (temperature),
    .pressure    (pressure),
    .clipped     (clipped)
  );

endmodule

/* src/btpc_checker.sv */
// ----------------------------------------------------------------------------
// btpc_checker
// Port-level checks of the compensation core, bound to the top level.
// ----------------------------------------------------------------------------
module btpc_checker
  import btpc_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   in_stall,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic signed [TEMP_W-1:0] temperature,
  input logic [PRESS_W-1:0]     pressure,
  input logic                   clipped
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_flow: assert property (@(posedge clk) disable iff (rst) !out_stall |-> !in_stall)
    else $error("input stalled while output drains");

  a_empty_takes: assert property (@(posedge clk) disable iff (rst) !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(temperature) && $stable(pressure)
      && $stable(clipped))
    else $error("stalled item changed");

endmodule

bind baro_temp_pressure_compensation_core btpc_checker u_btpc_checker (
  .clk         (clk),
  .rst         (rst),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .temperature (temperature),
  .pressure    (pressure),
  .clipped     (clipped)
);
